// File: sv/ps2_scancode_to_ascii_fifo_core_assert.svh
// Assertion macros for the PS/2 scancode to ASCII FIFO core.
// Checks compile only when SYNTHESIS is not defined; no other dependencies.
`ifndef PS2_SCANCODE_TO_ASCII_FIFO_CORE_ASSERT_SVH
`define PS2_SCANCODE_TO_ASCII_FIFO_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define PS2KBD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PS2KBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PS2KBD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define PS2KBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: sv/ps2kbd_pkg.sv
// Shared constants, operation codes and the set-2 keymap for the PS/2 decoder.
// No dependencies; used by the response channel interface and the core.
package ps2kbd_pkg;

   localparam int BUFFER_DEPTH_DEF = 64;
   localparam int CNT_W_DEF        = $clog2(BUFFER_DEPTH_DEF + 1);

   localparam logic [7:0] BREAK_PREFIX = 8'hF0;
   localparam logic [7:0] MAP_LIMIT    = 8'h70;

   typedef enum logic [0:0] {
      OP_SCAN = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // Set-2 make code to ASCII; zero means the key is not mapped.
   function automatic logic [6:0] key_lookup(input logic [7:0] code);
      logic [6:0] ch;
      case (code)
         8'h15: ch = 7'h71; // q
         8'h16: ch = 7'h31; // 1
         8'h1A: ch = 7'h7A; // z
         8'h1B: ch = 7'h73; // s
         8'h1C: ch = 7'h61; // a
         8'h1D: ch = 7'h77; // w
         8'h1E: ch = 7'h32; // 2
         8'h21: ch = 7'h63; // c
         8'h22: ch = 7'h78; // x
         8'h23: ch = 7'h64; // d
         8'h24: ch = 7'h65; // e
         8'h25: ch = 7'h34; // 4
         8'h26: ch = 7'h33; // 3
         8'h29: ch = 7'h20; // space
         8'h2A: ch = 7'h76; // v
         8'h2B: ch = 7'h66; // f
         8'h2C: ch = 7'h74; // t
         8'h2D: ch = 7'h72; // r
         8'h2E: ch = 7'h35; // 5
         8'h31: ch = 7'h6E; // n
         8'h32: ch = 7'h62; // b
         8'h33: ch = 7'h68; // h
         8'h34: ch = 7'h67; // g
         8'h35: ch = 7'h79; // y
         8'h36: ch = 7'h36; // 6
         8'h3A: ch = 7'h6D; // m
         8'h3B: ch = 7'h6A; // j
         8'h3C: ch = 7'h75; // u
         8'h3D: ch = 7'h37; // 7
         8'h3E: ch = 7'h38; // 8
         8'h41: ch = 7'h2C; // comma
         8'h42: ch = 7'h6B; // k
         8'h43: ch = 7'h69; // i
         8'h44: ch = 7'h6F; // o
         8'h45: ch = 7'h30; // 0
         8'h46: ch = 7'h39; // 9
         8'h49: ch = 7'h2E; // period
         8'h4A: ch = 7'h2F; // slash
         8'h4B: ch = 7'h6C; // l
         8'h4C: ch = 7'h3A; // colon
         8'h4D: ch = 7'h70; // p
         8'h52: ch = 7'h27; // apostrophe
         8'h54: ch = 7'h5B; // left bracket
         8'h5A: ch = 7'h0A; // enter, newline
         8'h5B: ch = 7'h5D; // right bracket
         8'h66: ch = 7'h08; // backspace
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

// File: sv/ps2kbd_if.sv
// Valid/ready channel interfaces for the PS/2 decoder request and response.
// Depends on ps2kbd_pkg for the default count width.
interface ps2kbd_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] scan_byte;

   modport source (output valid, output operation, output scan_byte, input ready);
   modport sink   (input valid, input operation, input scan_byte, output ready);
endinterface

interface ps2kbd_rsp_if #(
   parameter int CNT_W = ps2kbd_pkg::CNT_W_DEF
);
   logic             valid;
   logic             ready;
   logic [6:0]       read_char;
   logic             read_valid;
   logic             char_stored;
   logic [CNT_W-1:0] fill_level;

   modport source (output valid, output read_char, output read_valid,
                   output char_stored, output fill_level, input ready);
   modport sink   (input valid, input read_char, input read_valid,
                   input char_stored, input fill_level, output ready);
endinterface

// File: sv/ps2_scancode_to_ascii_fifo_core.sv
// PS/2 set-2 scancode decoder with an ASCII character ring buffer.
// Depends on ps2kbd_pkg, the ps2kbd channel interfaces and the assertion header.
//
// The block takes one request per cycle while responses are taken: either a raw set-2 scancode byte
// (operation 0) or a read of one character (operation 1). A break prefix
// (F0) arms a flag; the next mapped make code, looked up in the 112-entry
// keymap, pushes its ASCII character into a BUFFER_DEPTH-deep ring buffer and
// disarms the flag. Unmapped codes are ignored and keep the flag; make codes
// without a prefix are ignored. While the buffer is full every scancode byte
// is dropped, the prefix too. A read pops the oldest character, or returns
// read_valid low and read_char zero when the buffer is empty. Every request
// produces exactly one response carrying the fill level after that request.
// Throughput is one request per cycle while responses are taken: the state
// update and keymap lookup complete in the accept cycle, and the response
// lands in a single output register together with the registered read of the
// character memory. The request side stays ready while a response waits, as
// long as that response is taken in the same cycle. No clearing pass runs
// after reset; unwritten slots may be read but are never returned.
`include "ps2_scancode_to_ascii_fifo_core_assert.svh"

module ps2_scancode_to_ascii_fifo_core #(
   parameter int BUFFER_DEPTH = ps2kbd_pkg::BUFFER_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   ps2kbd_req_if.sink       req_ch,
   ps2kbd_rsp_if.source     rsp_ch
);
   import ps2kbd_pkg::*;

   localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

   // Character memory: one write port, one registered read port.
   logic [6:0] char_mem [BUFFER_DEPTH];

   // Control state
   logic             break_ff,  break_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Response payload
   logic [6:0]       rd_char_ff;
   logic             read_valid_ff;
   logic             char_stored_ff;
   logic [CNT_W-1:0] fill_level_ff;

   logic       accept;
   logic       is_read;
   logic       has_room;
   logic       is_prefix;
   logic [6:0] key_char;
   logic       set_break;
   logic       push_en;
   logic       pop_en;

   // Take a new request whenever the output register is empty or draining.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      is_read   = (req_ch.operation == OP_READ);
      has_room  = (count_ff < CNT_FULL);
      is_prefix = (req_ch.scan_byte == BREAK_PREFIX);
      key_char  = key_lookup(req_ch.scan_byte);

      // Drop every scancode while full; otherwise arm on prefix, push on a
      // mapped code that follows a prefix.
      set_break = accept && !is_read && has_room && is_prefix;
      push_en   = accept && !is_read && has_room && !is_prefix && break_ff
                  && (req_ch.scan_byte < MAP_LIMIT) && (key_char != 7'h00);
      pop_en    = accept && is_read && (count_ff != '0);
   end

   // Next state for flag, pointers and occupancy
   always_comb begin
      break_in = break_ff;
      if (set_break) begin
         break_in = 1'b1;
      end else if (push_en) begin
         break_in = 1'b0;
      end

      wr_ptr_in = wr_ptr_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end

      rd_ptr_in = rd_ptr_ff;
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end

      count_in = count_ff;
      if (push_en) begin
         count_in = count_ff + 1'b1;
      end else if (pop_en) begin
         count_in = count_ff - 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         break_ff     <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         break_ff     <= break_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Write the decoded character at the tail slot.
   always_ff @(posedge clock) begin
      if (push_en) begin
         char_mem[wr_ptr_ff] <= key_char;
      end
   end

   // Read the head slot on every transfer; hold it with the rest of the
   // response while the sink stalls.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_char_ff     <= char_mem[rd_ptr_ff];
         read_valid_ff  <= pop_en;
         char_stored_ff <= push_en;
         fill_level_ff  <= count_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_char   = read_valid_ff ? rd_char_ff : 7'h00;
   assign rsp_ch.read_valid  = read_valid_ff;
   assign rsp_ch.char_stored = char_stored_ff;
   assign rsp_ch.fill_level  = fill_level_ff;

   // Occupancy never passes the buffer depth.
   `PS2KBD_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL, "count over depth")
   // A response never both pops and pushes.
   `PS2KBD_ASSERT_NOW(a_one_action, clock, reset, rsp_valid_ff, !(read_valid_ff && char_stored_ff), "push and pop in one response")
   // A push grows the occupancy by exactly one.
   `PS2KBD_ASSERT_NEXT(a_push_count, clock, reset, push_en, count_ff == CNT_W'($past(count_ff) + 1'b1), "push count step")
   // The reported fill level tracks the occupancy after the transfer.
   `PS2KBD_ASSERT_NEXT(a_fill_level, clock, reset, accept, fill_level_ff == count_ff, "fill level mismatch")

endmodule
